>>> rtl/byte_and_pair_histogram_assert.svh
// Assertion macros for the byte and pair histogram.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BYTE_AND_PAIR_HISTOGRAM_ASSERT_SVH
`define BYTE_AND_PAIR_HISTOGRAM_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define BPH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("histogram check failed");

// Antecedent implies consequent in the next cycle.
`define BPH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("histogram check failed");

`endif

>>> rtl/bph_pkg.sv
// Shared types, constants and helpers for the byte and pair histogram.
// No dependencies.
package bph_pkg;

  localparam int COUNT_BITS = 32;
  localparam int FIELD_BITS = 32;
  localparam int BYTE_BITS  = 8;
  localparam int PAIR_BITS  = 2 * BYTE_BITS;
  localparam int BIT_LANES  = BYTE_BITS;
  localparam int LANE_BITS  = $clog2(BIT_LANES);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [BYTE_BITS-1:0]  byte_t;
  typedef logic [PAIR_BITS-1:0]  pair_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ACCUM    = 2'd0,
    OP_READ_BIN = 2'd1,
    OP_READ_BIT = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  // Saturating increment.
  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

  // Clamp a counter to the width of a result field.
  function automatic field_t to_field(count_t c);
    field_t f;
    f = FIELD_BITS'(c);
    if (c > count_t'({FIELD_BITS{1'b1}})) begin
      f = '1;
    end
    return f;
  endfunction

endpackage

>>> rtl/byte_and_pair_histogram.sv
// Byte and byte-pair histogram top level.
// Depends on bph_pkg and byte_and_pair_histogram_assert.svh.

// Each request is accepted in the idle state, which issues the read of the byte
// and pair count memories into the read data registers; the execute state then
// writes the incremented count back or loads the result register. A read request
// waits in the execute state while the previous result is still not taken.
// After reset and after every clear request the block sweeps the 65536-entry
// pair memory (and the 256-entry byte memory with it), one entry a cycle, and
// accepts no request until the sweep ends; configuration writes are taken
// at any time. Bit counters and the byte total are flip-flops and clear at once.
module byte_and_pair_histogram
  import bph_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode_i,
  input  logic [BYTE_BITS-1:0] data_byte_i,
  input  logic [PAIR_BITS-1:0] bin_index_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FIELD_BITS-1:0] read_value_o,
  output logic [FIELD_BITS-1:0] total_bytes_o,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data_i
);

  state_e state_q, state_d;
  op_e    op_q;
  pair_t  index_q;
  logic   pair_hit_q;
  logic   pair_mode_q;
  byte_t  prev_q;
  logic   have_prev_q;
  count_t total_q;
  count_t bit_cnt_q [BIT_LANES];
  pair_t  clear_addr_q;

  logic   out_valid_q;
  field_t read_value_q, total_bytes_q;

  count_t byte_mem [2**BYTE_BITS];
  count_t pair_mem [2**PAIR_BITS];
  count_t byte_rdata_q, pair_rdata_q;

  logic   in_fire, read_load, is_accum, is_read, clear_start;
  byte_t  byte_raddr, byte_waddr;
  pair_t  pair_raddr, pair_waddr;
  logic   byte_we, pair_we;
  count_t byte_wdata, pair_wdata;
  count_t result;

  assign in_ready  = (state_q == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign is_accum  = (state_q == S_EXEC) && (op_q == OP_ACCUM);
  assign is_read   = (state_q == S_EXEC) && (op_q == OP_READ_BIN || op_q == OP_READ_BIT);
  assign read_load = is_read && (!out_valid_q || out_ready);
  assign clear_start = (state_q == S_EXEC) && (op_q == OP_CLEAR);

  // Memory addressing: accumulate uses the byte, reads use the bin index.
  always_comb begin
    if (op_e'(opcode_i) == OP_ACCUM) begin
      byte_raddr = data_byte_i;
      pair_raddr = {prev_q, data_byte_i};
    end else begin
      byte_raddr = bin_index_i[BYTE_BITS-1:0];
      pair_raddr = bin_index_i;
    end
  end

  always_comb begin
    if (state_q == S_CLEAR) begin
      byte_we    = 1'b1;
      pair_we    = 1'b1;
      byte_waddr = clear_addr_q[BYTE_BITS-1:0];
      pair_waddr = clear_addr_q;
      byte_wdata = '0;
      pair_wdata = '0;
    end else begin
      byte_we    = is_accum && !pair_mode_q;
      pair_we    = is_accum && pair_mode_q && pair_hit_q;
      byte_waddr = index_q[BYTE_BITS-1:0];
      pair_waddr = index_q;
      byte_wdata = sat_inc(byte_rdata_q);
      pair_wdata = sat_inc(pair_rdata_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= byte_wdata;
    end
    if (in_fire) begin
      byte_rdata_q <= byte_mem[byte_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    if (in_fire) begin
      pair_rdata_q <= pair_mem[pair_raddr];
    end
  end

  // Result selection from the registered memory data or the bit counters.
  always_comb begin
    result = '0;
    if (op_q == OP_READ_BIN) begin
      if (pair_mode_q) begin
        result = pair_rdata_q;
      end else if (index_q[PAIR_BITS-1:BYTE_BITS] == '0) begin
        result = byte_rdata_q;
      end
    end else if (index_q[PAIR_BITS-1:LANE_BITS] == '0) begin
      result = bit_cnt_q[index_q[LANE_BITS-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clear_addr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (clear_start) begin
          state_d = S_CLEAR;
        end else if (!is_read || read_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clear_addr_q <= '0;
      pair_mode_q  <= 1'b0;
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      op_q         <= OP_ACCUM;
      for (int j = 0; j < BIT_LANES; j++) begin
        bit_cnt_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid) begin
        pair_mode_q <= cfg_data_i;
      end
      if (state_q == S_CLEAR) begin
        clear_addr_q <= clear_addr_q + pair_t'(1);
      end
      if (in_fire) begin
        op_q <= op_e'(opcode_i);
        if (op_e'(opcode_i) == OP_ACCUM) begin
          total_q     <= sat_inc(total_q);
          prev_q      <= data_byte_i;
          have_prev_q <= 1'b1;
          if (!pair_mode_q) begin
            for (int j = 0; j < BIT_LANES; j++) begin
              if (data_byte_i[j]) bit_cnt_q[j] <= sat_inc(bit_cnt_q[j]);
            end
          end
        end
      end
      if (clear_start) begin
        clear_addr_q <= '0;
        prev_q       <= '0;
        have_prev_q  <= 1'b0;
        total_q      <= '0;
        for (int j = 0; j < BIT_LANES; j++) begin
          bit_cnt_q[j] <= '0;
        end
      end
      // Drop the result once taken, load a fresh one when the slot is free.
      if (read_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      index_q    <= (op_e'(opcode_i) == OP_ACCUM) ? pair_raddr : bin_index_i;
      pair_hit_q <= have_prev_q;
    end
    if (read_load) begin
      read_value_q  <= to_field(result);
      total_bytes_q <= to_field(total_q);
    end
  end

  assign out_valid     = out_valid_q;
  assign read_value_o  = read_value_q;
  assign total_bytes_o = total_bytes_q;

`include "byte_and_pair_histogram_assert.svh"

  `BPH_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q))
  `BPH_ASSERT_NOW(a_clear_zeroed, state_q == S_CLEAR, total_q == '0 && !have_prev_q)
  `BPH_ASSERT_NOW(a_result_from_exec, $rose(out_valid_q), $past(state_q) == S_EXEC)
  `BPH_ASSERT_NEXT(a_total_grows, in_fire && op_e'(opcode_i) == OP_ACCUM,
                   total_q != '0 && total_q >= $past(total_q))
  `BPH_ASSERT_NOW(a_no_write_when_idle, state_q == S_IDLE, !byte_we && !pair_we)

endmodule
